// ----- rtl/rcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rcs_pkg;

    localparam int unsigned THRESH_W  = 8;
    localparam int unsigned STEPS_W   = 20;
    localparam int unsigned DIVIDE_W  = 6;
    localparam int unsigned CFG_IDX_W = 3;

    // request codes
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_PIXEL  = 2'd1;
    localparam logic [1:0] ACT_COLUMN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RAISE_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_STEPS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAISE_STEPS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_RAISE_STEPS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_PITCH_STEPS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RETURN_STEPS       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_PITCH_STEPS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Z_TICK_DIVIDE      = 3'd7;

    localparam logic [THRESH_W-1:0] RST_RAISE_THRESHOLD    = 8'd127;
    localparam logic [STEPS_W-1:0]  RST_LOWER_STEPS        = 20'd8000;
    localparam logic [STEPS_W-1:0]  RST_RAISE_STEPS        = 20'd1000;
    localparam logic [STEPS_W-1:0]  RST_COLUMN_RAISE_STEPS = 20'd8000;
    localparam logic [STEPS_W-1:0]  RST_PIXEL_PITCH_STEPS  = 20'd400;
    localparam logic [STEPS_W-1:0]  RST_RETURN_STEPS       = 20'd79600;
    localparam logic [STEPS_W-1:0]  RST_COLUMN_PITCH_STEPS = 20'd400;
    localparam logic [DIVIDE_W-1:0] RST_Z_TICK_DIVIDE      = 6'd6;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] pixel_value;
    } in_item_t;

    typedef struct packed {
        logic       x_step_level;
        logic       y_step_level;
        logic       y_direction;
        logic [3:0] z_coils;
        logic       spindle_on;
        logic       busy_res;
        logic       rejected;
    } out_item_t;

    typedef struct packed {
        logic [THRESH_W-1:0] raise_threshold;
        logic [STEPS_W-1:0]  lower_steps;
        logic [STEPS_W-1:0]  raise_steps;
        logic [STEPS_W-1:0]  column_raise_steps;
        logic [STEPS_W-1:0]  pixel_pitch_steps;
        logic [STEPS_W-1:0]  return_steps;
        logic [STEPS_W-1:0]  column_pitch_steps;
        logic [DIVIDE_W-1:0] z_tick_divide;
    } cfg_t;

    // full-step coil sequence
    function automatic logic [3:0] coil_lookup(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'hA;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'h5;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rcs_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rcs_cfg
    import rcs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [STEPS_W-1:0]   wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raise_threshold    <= RST_RAISE_THRESHOLD;
            cfg_reg.lower_steps        <= RST_LOWER_STEPS;
            cfg_reg.raise_steps        <= RST_RAISE_STEPS;
            cfg_reg.column_raise_steps <= RST_COLUMN_RAISE_STEPS;
            cfg_reg.pixel_pitch_steps  <= RST_PIXEL_PITCH_STEPS;
            cfg_reg.return_steps       <= RST_RETURN_STEPS;
            cfg_reg.column_pitch_steps <= RST_COLUMN_PITCH_STEPS;
            cfg_reg.z_tick_divide      <= RST_Z_TICK_DIVIDE;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_RAISE_THRESHOLD:    cfg_reg.raise_threshold    <= wr_data[THRESH_W-1:0];
                REG_LOWER_STEPS:        cfg_reg.lower_steps        <= wr_data;
                REG_RAISE_STEPS:        cfg_reg.raise_steps        <= wr_data;
                REG_COLUMN_RAISE_STEPS: cfg_reg.column_raise_steps <= wr_data;
                REG_PIXEL_PITCH_STEPS:  cfg_reg.pixel_pitch_steps  <= wr_data;
                REG_RETURN_STEPS:       cfg_reg.return_steps       <= wr_data;
                REG_COLUMN_PITCH_STEPS: cfg_reg.column_pitch_steps <= wr_data;
                REG_Z_TICK_DIVIDE:      cfg_reg.z_tick_divide      <= wr_data[DIVIDE_W-1:0];
                default:                ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/rcs_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rcs_core
    import rcs_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 20
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fire,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output out_item_t     result
);

    logic [COUNT_WIDTH-1:0] x_rem_reg, x_rem_next;
    logic [COUNT_WIDTH-1:0] y_rem_reg, y_rem_next;
    logic [COUNT_WIDTH-1:0] z_rem_reg, z_rem_next;
    logic [1:0]             phase_reg, phase_next;
    logic [DIVIDE_W-1:0]    prescale_reg, prescale_next;
    logic                   lowered_reg, lowered_next;
    logic                   spindle_reg, spindle_next;
    logic                   x_pin_reg, x_pin_next;
    logic                   y_pin_reg, y_pin_next;
    logic                   y_dir_reg, y_dir_next;
    logic [3:0]             coils_reg, coils_next;
    logic                   moving_reg, moving_next;
    logic                   rejected;
    logic [DIVIDE_W-1:0]    prescale_inc;

    // fit a 20-bit register value into the counter width
    function automatic logic [COUNT_WIDTH-1:0] fit(input logic [STEPS_W-1:0] v);
        logic [31:0] wide;
        wide = {{(32-STEPS_W){1'b0}}, v};
        return wide[COUNT_WIDTH-1:0];
    endfunction

    assign prescale_inc = prescale_reg + 1'b1;

    always_comb
    begin
        x_rem_next    = x_rem_reg;
        y_rem_next    = y_rem_reg;
        z_rem_next    = z_rem_reg;
        phase_next    = phase_reg;
        prescale_next = prescale_reg;
        lowered_next  = lowered_reg;
        spindle_next  = spindle_reg;
        x_pin_next    = x_pin_reg;
        y_pin_next    = y_pin_reg;
        y_dir_next    = y_dir_reg;
        coils_next    = coils_reg;
        moving_next   = moving_reg;
        rejected      = 1'b0;

        case (item.action)
            ACT_TICK:
            begin
                if (z_rem_reg != '0)
                begin
                    // z owns the tick; x and y wait
                    if (prescale_inc >= cfg.z_tick_divide)
                    begin
                        prescale_next = '0;
                        phase_next    = lowered_reg ? phase_reg + 2'd1 : phase_reg - 2'd1;
                        coils_next    = coil_lookup(phase_next);
                        z_rem_next    = z_rem_reg - 1'b1;
                    end
                    else
                    begin
                        prescale_next = prescale_inc;
                    end
                end
                else
                begin
                    prescale_next = '0;
                    if (y_rem_reg != '0)
                    begin
                        y_pin_next = ~y_pin_reg;
                        y_rem_next = y_rem_reg - 1'b1;
                    end
                    if (x_rem_reg != '0)
                    begin
                        x_pin_next = ~x_pin_reg;
                        x_rem_next = x_rem_reg - 1'b1;
                    end
                end
                if (x_rem_next == '0 && y_rem_next == '0 && z_rem_next == '0)
                begin
                    moving_next = 1'b0;
                end
            end
            ACT_PIXEL:
            begin
                if (moving_reg)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    if (item.pixel_value > cfg.raise_threshold)
                    begin
                        spindle_next = 1'b0;
                        lowered_next = 1'b0;
                        z_rem_next   = lowered_reg ? fit(cfg.raise_steps) : '0;
                    end
                    else
                    begin
                        if (!lowered_reg)
                        begin
                            spindle_next = 1'b1;
                        end
                        lowered_next = 1'b1;
                        z_rem_next   = lowered_reg ? '0 : fit(cfg.lower_steps);
                    end
                    y_dir_next    = 1'b1;
                    y_rem_next    = fit(cfg.pixel_pitch_steps);
                    prescale_next = '0;
                    moving_next   = 1'b1;
                end
            end
            ACT_COLUMN:
            begin
                if (moving_reg)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    spindle_next  = 1'b0;
                    lowered_next  = 1'b0;
                    z_rem_next    = lowered_reg ? fit(cfg.column_raise_steps) : '0;
                    y_dir_next    = 1'b0;
                    y_rem_next    = fit(cfg.return_steps);
                    x_rem_next    = fit(cfg.column_pitch_steps);
                    prescale_next = '0;
                    moving_next   = 1'b1;
                end
            end
            default:
            begin
                rejected = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_rem_reg    <= '0;
            y_rem_reg    <= '0;
            z_rem_reg    <= '0;
            phase_reg    <= '0;
            prescale_reg <= '0;
            lowered_reg  <= 1'b0;
            spindle_reg  <= 1'b0;
            x_pin_reg    <= 1'b0;
            y_pin_reg    <= 1'b0;
            y_dir_reg    <= 1'b0;
            coils_reg    <= '0;
            moving_reg   <= 1'b0;
        end
        else if (fire)
        begin
            x_rem_reg    <= x_rem_next;
            y_rem_reg    <= y_rem_next;
            z_rem_reg    <= z_rem_next;
            phase_reg    <= phase_next;
            prescale_reg <= prescale_next;
            lowered_reg  <= lowered_next;
            spindle_reg  <= spindle_next;
            x_pin_reg    <= x_pin_next;
            y_pin_reg    <= y_pin_next;
            y_dir_reg    <= y_dir_next;
            coils_reg    <= coils_next;
            moving_reg   <= moving_next;
        end
    end

    always_comb
    begin
        result.x_step_level = x_pin_next;
        result.y_step_level = y_pin_next;
        result.y_direction  = y_dir_next;
        result.z_coils      = coils_next;
        result.spindle_on   = spindle_next;
        result.busy_res     = moving_next;
        result.rejected     = rejected;
    end

endmodule

`default_nettype wire

// ----- rtl/raster_carve_stepper_sequencer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Raster carving motion sequencer with x/y step-pulse axes, a four-phase full-step z axis
// and a spindle enable. Each request (tick, pixel command or column-end command) is taken
// when in_valid and in_ready are both high: the motion state updates at the accepting edge
// and the pin levels after that request are captured in the output register at that same
// edge. A new request is taken every cycle while the output register is empty or being
// drained, so the sustained rate is one request per clock; the output register alone
// separates the two sides. Pixel and column-end commands sent while motion is in progress
// are ignored and flagged as rejected. Configuration writes are taken at any time but should
// be made only while the block is idle; unknown register indexes are ignored.
module raster_carve_stepper_sequencer_top
    import rcs_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 20
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire in_item_t             in_data,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output out_item_t                 out_data,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [STEPS_W-1:0]   cfg_data
);

    cfg_t      cfg;
    out_item_t result;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    logic      fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;

    rcs_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rcs_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_data),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
